>>> src/stit_pkg.sv
// stit_pkg: shared types, constants and codes for the session table
// no dependencies; imported by every module of the block
`default_nettype none
package stit_pkg;

  localparam int SLOTS   = 128;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int USER_W  = 7;
  localparam int TOKEN_W = 64;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int OUT_IDX_W = 7;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(300);

  // register word index (paddr[2])
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXPIRED   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // request beat travelling down the row of cells
  typedef struct packed {
    logic               vld;
    action_t            action;
    logic [TIME_W-1:0]  now;
    logic [TOKEN_W-1:0] token;
    logic [USER_W-1:0]  user;
    logic               done;
    status_t            status;
    logic [IDX_W-1:0]   idx;
    logic [USER_W-1:0]  owner;
  } bus_t;

  // broadcast append write from the end of the row
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  now;
    logic [TOKEN_W-1:0] token;
    logic [USER_W-1:0]  user;
  } wr_t;

endpackage
`default_nettype wire

>>> src/stit_cell.sv
// stit_cell: one session slot plus one stage of the request row
// depends on stit_pkg
`default_nettype none
module stit_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [stit_pkg::IDX_W-1:0] cell_idx,
  input  wire logic [stit_pkg::CNT_W-1:0] fill,
  input  wire logic [stit_pkg::TMO_W-1:0] idle_timeout,
  input  wire stit_pkg::wr_t              wr,
  input  wire stit_pkg::bus_t             bus_i,
  output stit_pkg::bus_t                  bus_o
);
  import stit_pkg::*;

  logic               valid_r, valid_nxt;
  logic [TOKEN_W-1:0] token_r, token_nxt;
  logic [USER_W-1:0]  owner_r, owner_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  bus_t               bus_r, bus_nxt;

  logic [TIME_W-1:0]  idle;
  logic               expired;
  logic               active;

  assign idle    = bus_i.now - last_r;
  assign expired = idle > {{(TIME_W-TMO_W){1'b0}}, idle_timeout};
  // slots at or above the fill mark are never scanned
  assign active  = bus_i.vld && ({1'b0, cell_idx} < fill);

  always_comb begin
    valid_nxt = valid_r;
    token_nxt = token_r;
    owner_nxt = owner_r;
    last_nxt  = last_r;
    bus_nxt   = bus_i;
    if (active && !bus_i.done) begin
      case (bus_i.action)
        ACT_CREATE: begin
          if (!valid_r || expired) begin
            valid_nxt      = 1'b1;
            token_nxt      = bus_i.token;
            owner_nxt      = bus_i.user;
            last_nxt       = bus_i.now;
            bus_nxt.done   = 1'b1;
            bus_nxt.status = ST_OK;
            bus_nxt.idx    = cell_idx;
            bus_nxt.owner  = '0;
          end
        end
        ACT_FIND: begin
          if (valid_r && token_r == bus_i.token) begin
            bus_nxt.done = 1'b1;
            bus_nxt.idx  = cell_idx;
            if (expired) begin
              valid_nxt      = 1'b0;
              bus_nxt.status = ST_EXPIRED;
              bus_nxt.owner  = '0;
            end else begin
              last_nxt       = bus_i.now;
              bus_nxt.status = ST_OK;
              bus_nxt.owner  = owner_r;
            end
          end
        end
        ACT_INVAL: begin
          if (valid_r && owner_r == bus_i.user) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    // append from the end of the row, never overlaps a scan of this cell
    if (wr.en && wr.idx == cell_idx) begin
      valid_nxt = 1'b1;
      token_nxt = wr.token;
      owner_nxt = wr.user;
      last_nxt  = wr.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      bus_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      bus_r.vld <= bus_nxt.vld;
    end
    token_r      <= token_nxt;
    owner_r      <= owner_nxt;
    last_r       <= last_nxt;
    bus_r.action <= bus_nxt.action;
    bus_r.now    <= bus_nxt.now;
    bus_r.token  <= bus_nxt.token;
    bus_r.user   <= bus_nxt.user;
    bus_r.done   <= bus_nxt.done;
    bus_r.status <= bus_nxt.status;
    bus_r.idx    <= bus_nxt.idx;
    bus_r.owner  <= bus_nxt.owner;
  end

  assign bus_o = bus_r;

endmodule
`default_nettype wire

>>> src/session_table_with_idle_timeout_unit.sv
// session_table_with_idle_timeout_unit: top level, row of slot cells,
// fill mark, result staging and the configuration port
// depends on stit_pkg and stit_cell
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready  | in_tdata: request beat (112 bits)
//   out_    | out | out_tvalid / out_tready| out_tdata: result beat (16 bits)
//   cfg_    | in  | psel/penable/pwrite    | idle_timeout at byte address 0
//
// a request beat walks the row of SLOTS cells, one cell per cycle, and the
// result register loads once the beat leaves the last cell; in_tready rises
// in that same cycle, and the row length sets how long a request takes
// one request is in the row at a time; in_tready is high only when idle
// a finished result waits in the output register while the next request is
// taken and scanned; if it is still waiting then, the new result parks in a
// hold stage and in_tready stays low until out_tready frees the output
// synchronous active-low reset clears all valid marks, the fill mark and
// sets idle_timeout to 300
`default_nettype none
module session_table_with_idle_timeout_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // action[1:0], now_seconds[33:2], token_key[97:34], user_index[104:98]
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [stit_pkg::IN_DATA_W-1:0]  in_tdata,
  // status[1:0], slot_index[8:2], owner_user[15:9]
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [stit_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [stit_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output      logic [31:0]                     cfg_prdata,
  output      logic                            cfg_pready
);
  import stit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [TMO_W-1:0]    timeout_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_DATA_W-1:0] hold_r, hold_nxt;

  bus_t                bus_w [0:SLOTS];
  bus_t                end_b;
  wr_t                 wr;
  logic                in_acc;
  logic                end_hit;
  status_t             res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [USER_W-1:0]   res_owner;
  logic [OUT_DATA_W-1:0] res_data;
  logic                cfg_wr;

  // ---------------- configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == REG_IDLE_TIMEOUT);
  assign cfg_prdata = (cfg_paddr[2] == REG_IDLE_TIMEOUT)
                      ? {{(32-TMO_W){1'b0}}, timeout_r} : 32'd0;

  // ---------------- head of the row
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    bus_w[0].vld    = in_acc;
    bus_w[0].action = action_t'(in_tdata[1:0]);
    bus_w[0].now    = in_tdata[33:2];
    bus_w[0].token  = in_tdata[97:34];
    bus_w[0].user   = in_tdata[104:98];
    bus_w[0].done   = 1'b0;
    bus_w[0].status = ST_NOT_FOUND;
    bus_w[0].idx    = '0;
    bus_w[0].owner  = '0;
  end

  // ---------------- row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    stit_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (IDX_W'(i)),
      .fill         (fill_r),
      .idle_timeout (timeout_r),
      .wr           (wr),
      .bus_i        (bus_w[i]),
      .bus_o        (bus_w[i+1])
    );
  end

  // ---------------- end of the row: append, full, miss
  assign end_b   = bus_w[SLOTS];
  assign end_hit = (state_r == S_SCAN) && end_b.vld;

  always_comb begin
    wr.en      = 1'b0;
    wr.idx     = fill_r[IDX_W-1:0];
    wr.now     = end_b.now;
    wr.token   = end_b.token;
    wr.user    = end_b.user;
    fill_nxt   = fill_r;
    res_status = end_b.status;
    res_idx    = end_b.idx;
    res_owner  = end_b.owner;
    if (!end_b.done) begin
      res_idx   = '0;
      res_owner = '0;
      case (end_b.action)
        ACT_CREATE: begin
          if (fill_r < CNT_W'(SLOTS)) begin
            // no reusable slot below the fill mark: take a fresh one
            wr.en      = end_hit;
            res_status = ST_OK;
            res_idx    = fill_r[IDX_W-1:0];
            if (end_hit) begin
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else begin
            res_status = ST_FULL;
          end
        end
        ACT_INVAL: res_status = ST_OK;
        default:   res_status = ST_NOT_FOUND;
      endcase
    end
  end

  assign res_data = {res_owner, OUT_IDX_W'(res_idx), res_status};

  // ---------------- control and result staging
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (end_b.vld) begin
          if (!out_valid_r || out_tready) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res_data;
            state_nxt     = S_IDLE;
          end else begin
            hold_nxt  = res_data;
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        timeout_r <= cfg_pwdata[TMO_W-1:0];
      end
    end
    out_data_r <= out_data_nxt;
    hold_r     <= hold_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
